FILE: rtl/sqvt_pkg.sv
// ----------------------------------------------------------------------------
// sqvt_pkg
// shared types and constants for the sprite quad vertex transform
// ----------------------------------------------------------------------------
package sqvt_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BITMAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BITMAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y      = 2'd3;

  localparam int ATAN_COUNT = 20;
  localparam int ANG_W = 26;

  // cordic gain 0.60725 in q16
  localparam logic signed [18:0] CORDIC_X0 = 19'sd39797;

  function automatic logic signed [ANG_W-1:0] atan_val(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0: v = 26'sd2097152;
      1: v = 26'sd1238021;
      2: v = 26'sd654136;
      3: v = 26'sd332050;
      4: v = 26'sd166669;
      5: v = 26'sd83416;
      6: v = 26'sd41718;
      7: v = 26'sd20860;
      8: v = 26'sd10430;
      9: v = 26'sd5215;
      10: v = 26'sd2608;
      11: v = 26'sd1304;
      12: v = 26'sd652;
      13: v = 26'sd326;
      14: v = 26'sd163;
      15: v = 26'sd81;
      16: v = 26'sd41;
      17: v = 26'sd20;
      18: v = 26'sd10;
      19: v = 26'sd5;
      default: v = '0;
    endcase
    return v;
  endfunction

  // trig pipeline stage payload
  typedef struct packed {
    logic signed [18:0] x;
    logic signed [18:0] y;
    logic signed [ANG_W-1:0] z;
    logic [1:0] quad;
  } cordic_t;

endpackage

FILE: rtl/sprite_quad_vertex_transform_top.sv
// ----------------------------------------------------------------------------
// sprite_quad_vertex_transform_top
// turns one sprite draw request into four transformed quad vertices
// ----------------------------------------------------------------------------
// Each accepted request yields four vertices, corners (x0,y0), (x1,y0),
// (x1,y1), (x0,y1), one per cycle on the result channel while the output is
// not stalled; the corner sequencer at the head of the transform pipeline
// holds off new requests until it has issued all four corners. A request
// enters a TRIG_ITERATIONS-stage cordic pipeline (one micro-rotation per
// stage), then the sequencer, then a four-stage multiply/sum pipeline and an
// output register that rounds, translates and saturates. All stages hold
// while the output is stalled; nothing is lost or repeated. Configuration is
// written through a plain write port; the user must write it only while idle,
// as the block itself does not enforce this.
module sprite_quad_vertex_transform_top #(
  parameter int SUBPIXEL_BITS = 4,
  parameter int TRIG_ITERATIONS = 14
) (
  input  logic clk,
  input  logic rst,
  // configuration
  input  logic cfg_write,
  input  logic [sqvt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sqvt_pkg::CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [15:0] screen_x,
  input  logic signed [15:0] screen_y,
  input  logic has_clip,
  input  logic signed [15:0] clip_left,
  input  logic signed [15:0] clip_right,
  input  logic signed [15:0] clip_top,
  input  logic signed [15:0] clip_bottom,
  input  logic [15:0] scale_factor,
  input  logic [15:0] angle,
  input  logic [31:0] tint_argb,
  input  logic signed [15:0] blend_mode,
  // vertex channel
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] corner_index,
  output logic signed [23:0] vertex_x,
  output logic signed [23:0] vertex_y,
  output logic [31:0] vertex_color,
  output logic signed [15:0] tex_u,
  output logic signed [15:0] tex_v,
  output logic signed [15:0] blend_out,
  output logic last_vertex
);

  localparam int NIT = TRIG_ITERATIONS;
  localparam int CW = 16 + SUBPIXEL_BITS + 2;  // corner width, covers default clip
  localparam int DW = CW + 1;                   // corner minus anchor

  // request payload carried alongside the cordic
  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] y1;
    logic [15:0] scale;
    logic [31:0] tint;
    logic signed [15:0] blend;
  } req_t;

  // per-vertex payload in the transform pipeline
  typedef struct packed {
    logic [1:0] k;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] tu;
    logic signed [15:0] tv;
    logic [31:0] tint;
    logic signed [15:0] blend;
  } vtx_t;

  // configuration registers
  logic [14:0] bitmap_width;
  logic [14:0] bitmap_height;
  logic signed [15:0] anchor_x;
  logic signed [15:0] anchor_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap_width <= '0;
      bitmap_height <= '0;
      anchor_x <= '0;
      anchor_y <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        sqvt_pkg::REG_BITMAP_WIDTH:  bitmap_width <= cfg_data[14:0];
        sqvt_pkg::REG_BITMAP_HEIGHT: bitmap_height <= cfg_data[14:0];
        sqvt_pkg::REG_ANCHOR_X:      anchor_x <= cfg_data;
        sqvt_pkg::REG_ANCHOR_Y:      anchor_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // global pipeline enable: whole datapath holds while the output register is
  // full and stalled; the sequencer additionally holds the trig pipeline
  // ---------------------------------------------------------------------------
  logic out_hold;
  logic seq_busy;       // sequencer still has corners to emit after this beat
  logic trig_adv;

  assign out_hold = out_valid && out_stall;
  assign trig_adv = !out_hold && !seq_busy;
  assign in_stall = !trig_adv;

  // ---------------------------------------------------------------------------
  // front: pick the source rectangle, reduce the angle
  // ---------------------------------------------------------------------------
  req_t req_in;
  sqvt_pkg::cordic_t cin;
  logic [15:0] ang_off;
  logic [1:0] quad_in;
  logic [15:0] resid;

  always_comb begin
    req_in.sx = screen_x;
    req_in.sy = screen_y;
    req_in.scale = scale_factor;
    req_in.tint = tint_argb;
    req_in.blend = blend_mode;
    if (has_clip) begin
      req_in.x0 = CW'(clip_left);
      req_in.x1 = CW'(clip_right);
      req_in.y0 = CW'(clip_top);
      req_in.y1 = CW'(clip_bottom);
    end else begin
      req_in.x0 = '0;
      req_in.x1 = CW'({1'b0, bitmap_width}) << SUBPIXEL_BITS;
      req_in.y0 = '0;
      req_in.y1 = CW'({1'b0, bitmap_height}) << SUBPIXEL_BITS;
    end
    ang_off = angle + 16'h2000;
    quad_in = ang_off[15:14];
    resid = angle - {quad_in, 14'd0};
    cin.x = sqvt_pkg::CORDIC_X0;
    cin.y = '0;
    cin.z = sqvt_pkg::ANG_W'($signed(resid)) <<< 8;
    cin.quad = quad_in;
  end

  // ---------------------------------------------------------------------------
  // cordic pipeline, one micro-rotation per stage
  // ---------------------------------------------------------------------------
  sqvt_pkg::cordic_t cst [NIT+1];
  req_t rst_q [NIT+1];
  logic cv [NIT+1];

  assign cst[0] = cin;
  assign rst_q[0] = req_in;
  assign cv[0] = in_valid;

  for (genvar i = 0; i < NIT; i++) begin : g_cordic
    sqvt_pkg::cordic_t nx;
    always_comb begin
      nx.quad = cst[i].quad;
      if (!cst[i].z[sqvt_pkg::ANG_W-1]) begin
        nx.x = cst[i].x - (cst[i].y >>> i);
        nx.y = cst[i].y + (cst[i].x >>> i);
        nx.z = cst[i].z - sqvt_pkg::atan_val(i);
      end else begin
        nx.x = cst[i].x + (cst[i].y >>> i);
        nx.y = cst[i].y - (cst[i].x >>> i);
        nx.z = cst[i].z + sqvt_pkg::atan_val(i);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (trig_adv) begin
        cv[i+1] <= cv[i];
      end
      if (trig_adv) begin
        cst[i+1] <= nx;
        rst_q[i+1] <= rst_q[i];
      end
    end
  end

  // quadrant fix-up, registered with the request at the sequencer
  logic signed [18:0] cos_v;
  logic signed [18:0] sin_v;
  always_comb begin
    case (cst[NIT].quad)
      2'd0: begin cos_v = cst[NIT].x;  sin_v = cst[NIT].y;  end
      2'd1: begin cos_v = -cst[NIT].y; sin_v = cst[NIT].x;  end
      2'd2: begin cos_v = -cst[NIT].x; sin_v = -cst[NIT].y; end
      default: begin cos_v = cst[NIT].y; sin_v = -cst[NIT].x; end
    endcase
  end

  // ---------------------------------------------------------------------------
  // corner sequencer: holds one request and steps k = 0..3
  // ---------------------------------------------------------------------------
  req_t sq_req;
  logic signed [18:0] sq_cos;
  logic signed [18:0] sq_sin;
  logic sq_valid;
  logic [1:0] sq_k;

  assign seq_busy = sq_valid && (sq_k != 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      sq_k <= '0;
    end else if (!out_hold) begin
      if (seq_busy) begin
        sq_k <= sq_k + 2'd1;
      end else begin
        sq_valid <= cv[NIT];
        sq_k <= '0;
      end
    end
    if (trig_adv) begin
      sq_req <= rst_q[NIT];
      sq_cos <= cos_v;
      sq_sin <= sin_v;
    end
  end

  // ---------------------------------------------------------------------------
  // transform pipeline
  //   t1: pick corner, subtract anchor
  //   t2: multiply by scale
  //   t3: four products by cos/sin
  //   t4: sums
  //   t5: round, translate, saturate
  // ---------------------------------------------------------------------------
  localparam int LW = DW + 17;   // d * scale
  localparam int PW = LW + 19;   // * trig
  localparam int SW = PW + 1;

  logic signed [CW-1:0] cu;
  logic signed [CW-1:0] cvv;
  always_comb begin
    cu = (sq_k == 2'd1 || sq_k == 2'd2) ? sq_req.x1 : sq_req.x0;
    cvv = sq_k[1] ? sq_req.y1 : sq_req.y0;
  end

  function automatic logic signed [15:0] sat16(input logic signed [CW-1:0] v);
    if (v > CW'(32767)) return 16'sd32767;
    if (v < -CW'(32768)) return -16'sd32768;
    return v[15:0];
  endfunction

  logic t1_v, t2_v, t3_v, t4_v;
  vtx_t t1_p, t2_p, t3_p, t4_p;
  logic signed [DW-1:0] t1_dx, t1_dy;
  logic [15:0] t1_sc;
  logic signed [18:0] t1_c, t1_s, t2_c, t2_s;
  logic signed [LW-1:0] t2_lx, t2_ly;
  logic signed [PW-1:0] t3_xc, t3_ys, t3_xs, t3_yc;
  logic signed [SW-1:0] t4_px, t4_py;

  logic signed [DW-1:0] ax_fix, ay_fix;
  assign ax_fix = DW'(anchor_x) <<< SUBPIXEL_BITS;
  assign ay_fix = DW'(anchor_y) <<< SUBPIXEL_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
      t2_v <= 1'b0;
      t3_v <= 1'b0;
      t4_v <= 1'b0;
    end else if (!out_hold) begin
      t1_v <= sq_valid;
      t2_v <= t1_v;
      t3_v <= t2_v;
      t4_v <= t3_v;
    end
    if (!out_hold) begin
      t1_p.k <= sq_k;
      t1_p.sx <= sq_req.sx;
      t1_p.sy <= sq_req.sy;
      t1_p.tu <= sat16(cu);
      t1_p.tv <= sat16(cvv);
      t1_p.tint <= sq_req.tint;
      t1_p.blend <= sq_req.blend;
      t1_dx <= DW'(cu) - ax_fix;
      t1_dy <= DW'(cvv) - ay_fix;
      t1_sc <= sq_req.scale;
      t1_c <= sq_cos;
      t1_s <= sq_sin;

      t2_p <= t1_p;
      t2_lx <= LW'(t1_dx) * $signed({1'b0, t1_sc});
      t2_ly <= LW'(t1_dy) * $signed({1'b0, t1_sc});
      t2_c <= t1_c;
      t2_s <= t1_s;

      t3_p <= t2_p;
      t3_xc <= PW'(t2_lx) * PW'(t2_c);
      t3_ys <= PW'(t2_ly) * PW'(t2_s);
      t3_xs <= PW'(t2_lx) * PW'(t2_s);
      t3_yc <= PW'(t2_ly) * PW'(t2_c);

      t4_p <= t3_p;
      t4_px <= SW'(t3_xc) - SW'(t3_ys) + (SW'(1) <<< 27);
      t4_py <= SW'(t3_xs) + SW'(t3_yc) + (SW'(1) <<< 27);
    end
  end

  // round (floor after bias), translate, saturate
  logic signed [SW-1:0] fx, fy;
  always_comb begin
    fx = (t4_px >>> 28) + (SW'(t4_p.sx) <<< SUBPIXEL_BITS);
    fy = (t4_py >>> 28) + (SW'(t4_p.sy) <<< SUBPIXEL_BITS);
  end

  function automatic logic signed [23:0] sat24(input logic signed [SW-1:0] v);
    if (v > SW'(8388607)) return 24'sd8388607;
    if (v < -SW'(8388608)) return -24'sd8388608;
    return v[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_hold) begin
      out_valid <= t4_v;
    end
    if (!out_hold) begin
      corner_index <= t4_p.k;
      vertex_x <= sat24(fx);
      vertex_y <= sat24(fy);
      vertex_color <= t4_p.tint;
      tex_u <= t4_p.tu;
      tex_v <= t4_p.tv;
      blend_out <= t4_p.blend;
      last_vertex <= (t4_p.k == 2'd3);
    end
  end

`ifndef SYNTHESIS
  // a stalled request is never taken while the sequencer is mid-quad
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    seq_busy |-> in_stall)
    else $error("request taken while corners pending");
  // corners advance one step per beat while the output is not held
  a_corner_step: assert property (@(posedge clk) disable iff (rst)
    (sq_valid && !out_hold && seq_busy) |=> (sq_k == $past(sq_k) + 2'd1))
    else $error("corner sequence skipped");
  // last flag marks corner three only
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_vertex == (corner_index == 2'd3)))
    else $error("last flag mismatch");
  // held output does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    $past(out_hold) |-> (out_valid && $stable(vertex_x) && $stable(corner_index)))
    else $error("held vertex changed");
`endif

endmodule
